// ===== design/bde_pkg.sv =====
// Shared types and constants for the bounded deque engine.
// No dependencies; every other design file imports this package.
package bde_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned CAP_WIDTH = 4;
   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 4'd5;

   // Operation codes carried in the mode field of a request.
   localparam logic [2:0] MODE_PUSH_LEFT = 3'd0;
   localparam logic [2:0] MODE_PUSH_RIGHT = 3'd1;
   localparam logic [2:0] MODE_POP_LEFT = 3'd2;
   localparam logic [2:0] MODE_POP_RIGHT = 3'd3;
   localparam logic [2:0] MODE_DUMP_FWD = 3'd4;
   localparam logic [2:0] MODE_DUMP_BWD = 3'd5;

   typedef enum logic [1:0] {
      STATUS_ENTRY = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_NOW_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_STATUS,
      STATE_DUMP_FWD,
      STATE_DUMP_BWD
   } state_type;

   // What every cell of the row does at the next clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT,
      CELL_APPEND
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic ring;
      logic signed [DATA_WIDTH-1:0] push_value;
   } cell_ctrl_type;

endpackage

// ===== design/bde_cell.sv =====
// One storage cell of the deque row: holds a single entry.
// Depends on bde_pkg for the cell command types.
module bde_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned FW = 4
) (
   input  logic clock,
   input  bde_pkg::cell_ctrl_type ctrl,
   input  logic [FW-1:0] fill,
   input  logic signed [bde_pkg::DATA_WIDTH-1:0] left_data,
   input  logic signed [bde_pkg::DATA_WIDTH-1:0] right_data,
   output logic signed [bde_pkg::DATA_WIDTH-1:0] data
);
   import bde_pkg::*;

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CELL_HOLD: data_in = data_ff;
         CELL_TAKE_LEFT: data_in = left_data;
         CELL_TAKE_RIGHT: data_in = right_data;
         CELL_APPEND: begin
            // Only the cell just right of the last entry takes the value.
            if (fill == FW'(INDEX)) begin
               data_in = ctrl.push_value;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/bde_chain.sv =====
// Row of deque cells wired as a ring; cell 0 holds the leftmost entry.
// Depends on bde_pkg and bde_cell.
module bde_chain #(
   parameter int unsigned DEPTH = 8,
   parameter int unsigned FW = 4
) (
   input  logic clock,
   input  bde_pkg::cell_ctrl_type ctrl,
   input  logic [FW-1:0] fill,
   output logic signed [bde_pkg::DATA_WIDTH-1:0] head_data,
   output logic signed [bde_pkg::DATA_WIDTH-1:0] tail_data
);
   import bde_pkg::*;

   logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic signed [DATA_WIDTH-1:0] left_in [DEPTH];
   logic signed [DATA_WIDTH-1:0] right_in [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // The first cell takes the pushed value on a left push, or the last
      // cell when the ring turns right.
      if (i == 0) begin : g_first
         assign left_in[i] = ctrl.ring ? cell_data[DEPTH-1] : ctrl.push_value;
      end else begin : g_inner_left
         assign left_in[i] = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_in[i] = cell_data[0];
      end else begin : g_inner_right
         assign right_in[i] = cell_data[i+1];
      end

      bde_cell #(
         .INDEX(i),
         .FW(FW)
      ) u_cell (
         .clock(clock),
         .ctrl(ctrl),
         .fill(fill),
         .left_data(left_in[i]),
         .right_data(right_in[i]),
         .data(cell_data[i])
      );
   end

   assign head_data = cell_data[0];
   assign tail_data = cell_data[DEPTH-1];

endmodule

// ===== design/bounded_deque_engine.sv =====
// Bounded deque engine: requests are taken while idle and answered by a registered response.
// A push or pop that leaves entries, and any dump of a non-empty deque, then runs DEPTH ring
// rotations with requests stalled; status-only requests use a status state; unknown modes drop.
// The row of cells is the limiting resource: one entry leaves per cycle while rsp_stall is low.
// Synchronous reset empties the deque, sets capacity to 5 and drops any pending response;
// the entry cells themselves are not cleared.
module bounded_deque_engine #(
   parameter int unsigned DEPTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_mode,
   input  logic signed [31:0] req_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_entry,
   output logic [1:0] rsp_status,
   output logic rsp_last,
   output logic rsp_is_full,
   output logic rsp_is_empty,
   input  logic csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   import bde_pkg::*;

   // FW holds a fill count of 0..DEPTH; CW is wide enough for both the count and the
   // four bit capacity register so the fullness compare is lossless.
   localparam int unsigned FW = $clog2(DEPTH + 1);
   localparam int unsigned CW = (FW > CAP_WIDTH) ? FW : CAP_WIDTH;
   localparam logic [FW-1:0] LAST_STEP = FW'(DEPTH - 1);

   state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] step_ff, step_in;
   status_type status_ff, status_in;
   logic [CAP_WIDTH-1:0] capacity_ff, capacity_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_entry_ff;
   status_type rsp_status_ff;
   logic rsp_last_ff, rsp_full_ff, rsp_empty_ff;

   cell_ctrl_type chain_ctrl;
   logic signed [DATA_WIDTH-1:0] head_data, tail_data;

   logic [CW-1:0] cap_eff;
   logic is_full, is_empty;
   logic out_free, out_load, emit;
   logic signed [DATA_WIDTH-1:0] out_entry;
   status_type out_status;
   logic out_last;
   logic [FW:0] bwd_pos;

   // The entries live in a row of cells, leftmost entry in cell 0. Left pushes
   // and left pops shift the whole row by one place; a right push writes the
   // cell just past the last entry; a right pop only lowers the count.
   bde_chain #(
      .DEPTH(DEPTH),
      .FW(FW)
   ) u_chain (
      .clock(clock),
      .ctrl(chain_ctrl),
      .fill(fill_ff),
      .head_data(head_data),
      .tail_data(tail_data)
   );

   // Capacity above DEPTH saturates. When the count sits at or above the
   // effective capacity (including capacity zero) the deque reads as full.
   always_comb begin
      cap_eff = (CW'(capacity_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_ff);
   end
   assign is_full = (CW'(fill_ff) >= cap_eff);
   assign is_empty = (fill_ff == '0);

   // The response register frees up when it is empty or is being taken now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A backward dump emits the tail cell once the ring has turned right by
   // DEPTH - fill places, which puts the rightmost entry in the last cell.
   assign bwd_pos = {1'b0, step_ff} + {1'b0, fill_ff};

   always_comb begin
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      step_in = step_ff;
      status_in = status_ff;
      chain_ctrl.cmd = CELL_HOLD;
      chain_ctrl.ring = 1'b0;
      chain_ctrl.push_value = req_value;
      out_load = 1'b0;
      out_entry = '0;
      out_status = STATUS_ENTRY;
      out_last = 1'b0;
      emit = 1'b0;
      req_stall = (state_ff != STATE_IDLE);

      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               unique case (req_mode) inside
                  MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                        state_in = STATE_STATUS;
                     end else begin
                        chain_ctrl.cmd = (req_mode == MODE_PUSH_LEFT) ?
                                         CELL_TAKE_LEFT : CELL_APPEND;
                        fill_in = fill_ff + FW'(1);
                        step_in = '0;
                        state_in = STATE_DUMP_FWD;
                     end
                  end
                  MODE_POP_LEFT, MODE_POP_RIGHT: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                        state_in = STATE_STATUS;
                     end else begin
                        chain_ctrl.cmd = (req_mode == MODE_POP_LEFT) ?
                                         CELL_TAKE_RIGHT : CELL_HOLD;
                        fill_in = fill_ff - FW'(1);
                        step_in = '0;
                        if (fill_ff == FW'(1)) begin
                           status_in = STATUS_NOW_EMPTY;
                           state_in = STATE_STATUS;
                        end else begin
                           state_in = STATE_DUMP_FWD;
                        end
                     end
                  end
                  MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                     step_in = '0;
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                        state_in = STATE_STATUS;
                     end else if (req_mode == MODE_DUMP_FWD) begin
                        state_in = STATE_DUMP_FWD;
                     end else begin
                        state_in = STATE_DUMP_BWD;
                     end
                  end
                  default: begin
                     // Unused modes are dropped without a response.
                  end
               endcase
            end
         end

         STATE_STATUS: begin
            if (out_free) begin
               out_load = 1'b1;
               out_status = status_ff;
               out_last = 1'b1;
               state_in = STATE_IDLE;
            end
         end

         STATE_DUMP_FWD: begin
            // Rotate the ring left DEPTH times; the first fill_ff steps show
            // the entries in cell 0 in left-to-right order.
            emit = (step_ff < fill_ff);
            out_entry = head_data;
            out_last = (step_ff == fill_ff - FW'(1));
            if (!emit || out_free) begin
               out_load = emit;
               chain_ctrl.cmd = CELL_TAKE_RIGHT;
               step_in = step_ff + FW'(1);
               if (step_ff == LAST_STEP) begin
                  state_in = STATE_IDLE;
               end
            end
         end

         STATE_DUMP_BWD: begin
            // Rotate the ring right DEPTH times; the last fill_ff steps show
            // the entries in the last cell in right-to-left order.
            emit = (bwd_pos >= (FW + 1)'(DEPTH));
            out_entry = tail_data;
            out_last = (step_ff == LAST_STEP);
            if (!emit || out_free) begin
               out_load = emit;
               chain_ctrl.cmd = CELL_TAKE_LEFT;
               chain_ctrl.ring = 1'b1;
               step_in = step_ff + FW'(1);
               if (step_ff == LAST_STEP) begin
                  state_in = STATE_IDLE;
               end
            end
         end

         default: state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         fill_ff <= '0;
         step_ff <= '0;
         capacity_ff <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         step_ff <= step_in;
         capacity_ff <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload and the pending status code need no reset. The flags
   // come from the count after the operation, which holds for the whole run.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (out_load) begin
         rsp_entry_ff <= out_entry;
         rsp_status_ff <= out_status;
         rsp_last_ff <= out_last;
         rsp_full_ff <= is_full;
         rsp_empty_ff <= is_empty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry = rsp_entry_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_is_full = rsp_full_ff;
   assign rsp_is_empty = rsp_empty_ff;

   // The count can never pass the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      CW'(fill_ff) <= CW'(DEPTH))
      else $error("fill count exceeds the number of cells");

   // An entry transaction is only ever produced while the deque holds data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ENTRY) |-> !rsp_is_empty)
      else $error("entry transaction while deque is empty");

   // A pop on an empty deque leaves the count untouched.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && is_empty &&
       (req_mode == MODE_POP_LEFT || req_mode == MODE_POP_RIGHT))
      |=> (fill_ff == $past(fill_ff)))
      else $error("pop on empty deque changed the count");

   // The request side is held off for as long as a dump sequence runs.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_DUMP_FWD || state_ff == STATE_DUMP_BWD) |-> req_stall)
      else $error("request accepted during a dump sequence");

endmodule
